/* sv/pbsm_pkg.sv */
package pbsm_pkg;

  localparam int unsigned SLOTS_DEF      = 8;
  localparam int unsigned ADDR_WIDTH_DEF = 32;
  localparam int unsigned AGE_WIDTH_DEF  = 16;

  // fixed widths of the beat fields
  localparam int unsigned PAGE_ADDR_W = 32;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned WB_ADDR_W   = 32;

  typedef enum logic [0:0] {
    OP_GET     = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

endpackage

/* sv/page_buffer_slot_manager_lru_unit.sv */
// a request is accepted only while idle; after the scan, the final state waits for a
// free output register, loads the result into it and returns to idle
// the scan reads the tag and age memories one slot per cycle through their read ports
// reset: asynchronous, active low; all slots free, no result pending, ready to accept
// tag and age memories are not cleared; ages are used for eviction only when every slot is filled
module page_buffer_slot_manager_lru_unit #(
  parameter int unsigned SLOTS      = pbsm_pkg::SLOTS_DEF,
  parameter int unsigned ADDR_WIDTH = pbsm_pkg::ADDR_WIDTH_DEF,
  parameter int unsigned AGE_WIDTH  = pbsm_pkg::AGE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [0:0]                        opcode_i,
  input  logic [pbsm_pkg::PAGE_ADDR_W-1:0]  page_addr_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pbsm_pkg::SLOT_W-1:0]       slot_o,
  output logic                              hit_o,
  output logic                              fill_needed_o,
  output logic                              writeback_needed_o,
  output logic [pbsm_pkg::WB_ADDR_W-1:0]    writeback_addr_o
);

  localparam int unsigned IDX_W = $clog2(SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // memories
  logic [ADDR_WIDTH-1:0] tag_mem [SLOTS];
  logic [AGE_WIDTH-1:0]  age_mem [SLOTS];
  logic [ADDR_WIDTH-1:0] tag_rd_q;
  logic [AGE_WIDTH-1:0]  age_rd_q;

  logic                  rd_en;
  logic                  tag_we;
  logic                  age_we;
  logic [IDX_W-1:0]      age_waddr;
  logic [AGE_WIDTH-1:0]  age_wdata;

  // control
  logic [SLOTS-1:0]      valid_q;
  logic                  issuing_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic                  proc_vld_q;
  logic [IDX_W-1:0]      proc_idx_q;
  logic                  found_q;
  logic                  free_found_q;
  logic                  out_valid_q;

  // request and scan results
  pbsm_pkg::op_e         op_q;
  logic [ADDR_WIDTH-1:0] addr_q;
  logic [IDX_W-1:0]      hit_idx_q;
  logic [IDX_W-1:0]      free_idx_q;
  logic [IDX_W-1:0]      max_idx_q;
  logic [AGE_WIDTH-1:0]  max_age_q;
  logic [ADDR_WIDTH-1:0] evict_tag_q;

  // output register
  logic [IDX_W-1:0]      res_slot_q;
  logic                  res_hit_q;
  logic                  res_fill_q;
  logic                  res_wb_q;
  logic [ADDR_WIDTH-1:0] res_wba_q;

  logic                      accept;
  logic                      fin_go;
  logic                      is_get;
  logic [AGE_WIDTH-1:0]      age_inc;
  logic                      tag_match;
  logic                      new_max;
  logic [IDX_W-1:0]          res_slot;
  logic                      res_hit;
  logic                      res_fill;
  logic                      res_wb;
  logic [ADDR_WIDTH-1:0]     res_wba;
  logic [pbsm_pkg::PAGE_ADDR_W+ADDR_WIDTH-1:0] addr_ext;
  logic [pbsm_pkg::WB_ADDR_W+ADDR_WIDTH-1:0]   wba_ext;
  logic [pbsm_pkg::SLOT_W+IDX_W-1:0]           slot_ext;

  assign accept   = in_valid_i && in_ready_o;
  assign is_get   = (op_q == pbsm_pkg::OP_GET);
  assign addr_ext = (pbsm_pkg::PAGE_ADDR_W + ADDR_WIDTH)'(page_addr_i);

  // saturating age of the slot being scanned
  assign age_inc   = (age_rd_q == {AGE_WIDTH{1'b1}}) ? age_rd_q : age_rd_q + AGE_WIDTH'(1);
  assign tag_match = valid_q[proc_idx_q] && (tag_rd_q == addr_q);
  // first slot of greatest aged value wins ties
  assign new_max   = (proc_idx_q == '0) || (age_inc > max_age_q);

  always_comb begin
    res_slot = '0;
    res_hit  = 1'b0;
    res_fill = 1'b0;
    res_wb   = 1'b0;
    res_wba  = '0;
    if (!is_get) begin
      if (found_q) begin
        res_slot = hit_idx_q;
        res_hit  = 1'b1;
        res_wb   = 1'b1;
        res_wba  = addr_q;
      end
    end else if (found_q) begin
      res_slot = hit_idx_q;
      res_hit  = 1'b1;
    end else if (free_found_q) begin
      res_slot = free_idx_q;
      res_fill = 1'b1;
    end else begin
      res_slot = max_idx_q;
      res_fill = 1'b1;
      res_wb   = 1'b1;
      res_wba  = evict_tag_q;
    end
  end

  assign fin_go = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  // scan writes back entry j while reading entry j+1; the final write comes after
  // the scan, so no two accesses to one entry overlap
  always_comb begin
    rd_en     = (state_q == ST_SCAN) && issuing_q;
    tag_we    = fin_go && is_get && !found_q;
    age_we    = 1'b0;
    age_waddr = proc_idx_q;
    age_wdata = age_inc;
    if (fin_go && is_get) begin
      age_we    = 1'b1;
      age_waddr = res_slot;
      age_wdata = '0;
    end else if ((state_q == ST_SCAN) && proc_vld_q && is_get) begin
      age_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[res_slot] <= addr_q;
    end
    if (rd_en) begin
      tag_rd_q <= tag_mem[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (age_we) begin
      age_mem[age_waddr] <= age_wdata;
    end
    if (rd_en) begin
      age_rd_q <= age_mem[rd_idx_q];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_SCAN;
      ST_SCAN: if (proc_vld_q && (proc_idx_q == IDX_W'(SLOTS - 1))) state_d = ST_FIN;
      ST_FIN:  if (fin_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      issuing_q    <= 1'b0;
      rd_idx_q     <= '0;
      proc_vld_q   <= 1'b0;
      proc_idx_q   <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        issuing_q    <= 1'b1;
        rd_idx_q     <= '0;
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
      end
      if (state_q == ST_SCAN) begin
        proc_vld_q <= issuing_q;
        if (issuing_q) begin
          proc_idx_q <= rd_idx_q;
          if (rd_idx_q == IDX_W'(SLOTS - 1)) begin
            issuing_q <= 1'b0;
          end else begin
            rd_idx_q <= rd_idx_q + IDX_W'(1);
          end
        end
        if (proc_vld_q) begin
          if (tag_match && !found_q) found_q <= 1'b1;
          if (!valid_q[proc_idx_q] && !free_found_q) free_found_q <= 1'b1;
        end
      end else begin
        proc_vld_q <= 1'b0;
      end
      if (fin_go) begin
        if (!is_get && found_q) begin
          valid_q[hit_idx_q] <= 1'b0;
        end else if (is_get && !found_q) begin
          valid_q[res_slot] <= 1'b1;
        end
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= pbsm_pkg::op_e'(opcode_i);
      addr_q <= addr_ext[ADDR_WIDTH-1:0];
    end
    if ((state_q == ST_SCAN) && proc_vld_q) begin
      if (tag_match && !found_q) hit_idx_q <= proc_idx_q;
      if (!valid_q[proc_idx_q] && !free_found_q) free_idx_q <= proc_idx_q;
      if (new_max) begin
        max_age_q   <= age_inc;
        max_idx_q   <= proc_idx_q;
        evict_tag_q <= tag_rd_q;
      end
    end
    if (fin_go) begin
      res_slot_q <= res_slot;
      res_hit_q  <= res_hit;
      res_fill_q <= res_fill;
      res_wb_q   <= res_wb;
      res_wba_q  <= res_wba;
    end
  end

  assign slot_ext = (pbsm_pkg::SLOT_W + IDX_W)'(res_slot_q);
  assign wba_ext  = (pbsm_pkg::WB_ADDR_W + ADDR_WIDTH)'(res_wba_q);

  assign in_ready_o         = (state_q == ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign slot_o             = slot_ext[pbsm_pkg::SLOT_W-1:0];
  assign hit_o              = res_hit_q;
  assign fill_needed_o      = res_fill_q;
  assign writeback_needed_o = res_wb_q;
  assign writeback_addr_o   = wba_ext[pbsm_pkg::WB_ADDR_W-1:0];

endmodule

/* tb/slot_lru_checker.sv */
`timescale 1ns / 100ps

module slot_lru_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [0:0]                       opcode_i,
  input  logic [pbsm_pkg::PAGE_ADDR_W-1:0] page_addr_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [pbsm_pkg::SLOT_W-1:0]      slot_i,
  input  logic                             hit_i,
  input  logic                             fill_needed_i,
  input  logic                             writeback_needed_i,
  input  logic [pbsm_pkg::WB_ADDR_W-1:0]   writeback_addr_i,
  output int                               fail_count_o,
  output int                               pending_o
);

  localparam int unsigned SLOTS = pbsm_pkg::SLOTS_DEF;
  localparam int unsigned AW    = pbsm_pkg::ADDR_WIDTH_DEF;
  localparam int unsigned GW    = pbsm_pkg::AGE_WIDTH_DEF;

  typedef struct packed {
    logic [pbsm_pkg::SLOT_W-1:0]    slot;
    logic                           hit;
    logic                           fill;
    logic                           wb;
    logic [pbsm_pkg::WB_ADDR_W-1:0] wb_addr;
  } slot_grant_t;

  bit [AW-1:0]  tag_q   [SLOTS];
  bit           slot_used [SLOTS];
  bit [GW-1:0]  age_q   [SLOTS];
  slot_grant_t  grants_due [$];
  int           errors = 0;

  function automatic slot_grant_t allocate_slot(input pbsm_pkg::op_e op,
                                                input logic [pbsm_pkg::PAGE_ADDR_W-1:0] addr);
    slot_grant_t g;
    logic [AW-1:0] a;
    int match;
    int pick;
    g = '0;
    a = AW'(addr);
    match = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (match < 0 && slot_used[i] && tag_q[i] == a) match = i;
    end
    if (op == pbsm_pkg::OP_RELEASE) begin
      // tag and age stay, only the valid bit drops
      if (match >= 0) begin
        slot_used[match] = 1'b0;
        g.slot    = pbsm_pkg::SLOT_W'(match);
        g.hit     = 1'b1;
        g.wb      = 1'b1;
        g.wb_addr = pbsm_pkg::WB_ADDR_W'(a);
      end
    end else if (match >= 0) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (i != match && age_q[i] != {GW{1'b1}}) age_q[i] = age_q[i] + 1'b1;
      end
      age_q[match] = '0;
      g.slot = pbsm_pkg::SLOT_W'(match);
      g.hit  = 1'b1;
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (age_q[i] != {GW{1'b1}}) age_q[i] = age_q[i] + 1'b1;
      end
      pick = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (pick < 0 && !slot_used[i]) pick = i;
      end
      if (pick < 0) begin
        // oldest slot goes, lowest index on a tie
        pick = 0;
        for (int i = 1; i < SLOTS; i++) begin
          if (age_q[i] > age_q[pick]) pick = i;
        end
        g.wb      = 1'b1;
        g.wb_addr = pbsm_pkg::WB_ADDR_W'(tag_q[pick]);
      end
      tag_q[pick]     = a;
      slot_used[pick] = 1'b1;
      age_q[pick]     = '0;
      g.slot = pbsm_pkg::SLOT_W'(pick);
      g.fill = 1'b1;
    end
    return g;
  endfunction

  task automatic check_field(input string name, input logic [pbsm_pkg::WB_ADDR_W-1:0] want,
                             input logic [pbsm_pkg::WB_ADDR_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    slot_grant_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (grants_due.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, expected none, got slot %0d",
                   $time, slot_i);
        end else begin
          want = grants_due.pop_front();
          check_field("slot", pbsm_pkg::WB_ADDR_W'(want.slot), pbsm_pkg::WB_ADDR_W'(slot_i));
          check_field("hit", pbsm_pkg::WB_ADDR_W'(want.hit), pbsm_pkg::WB_ADDR_W'(hit_i));
          check_field("fill_needed", pbsm_pkg::WB_ADDR_W'(want.fill),
                      pbsm_pkg::WB_ADDR_W'(fill_needed_i));
          check_field("writeback_needed", pbsm_pkg::WB_ADDR_W'(want.wb),
                      pbsm_pkg::WB_ADDR_W'(writeback_needed_i));
          check_field("writeback_addr", want.wb_addr, writeback_addr_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        grants_due.push_back(allocate_slot(pbsm_pkg::op_e'(opcode_i), page_addr_i));
      end
    end
    fail_count_o <= errors;
    pending_o    <= grants_due.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned POOL_SIZE   = 12;
  localparam int unsigned PER_PHASE   = 100;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             req_valid;
  logic                             req_ready;
  logic [0:0]                       req_op;
  logic [pbsm_pkg::PAGE_ADDR_W-1:0] req_addr;
  logic                             res_valid;
  logic                             res_ready;
  logic [pbsm_pkg::SLOT_W-1:0]      res_slot;
  logic                             res_hit;
  logic                             res_fill;
  logic                             res_wb;
  logic [pbsm_pkg::WB_ADDR_W-1:0]   res_wb_addr;
  int                               fail_count;
  int                               pending;

  int                               send_idle_pct = 36;
  int                               recv_idle_pct = 55;
  int                               n_get = 0;
  int                               n_release = 0;
  logic [pbsm_pkg::PAGE_ADDR_W-1:0] page_pool [POOL_SIZE];
  logic [pbsm_pkg::PAGE_ADDR_W-1:0] pages_seen [$];

  page_buffer_slot_manager_lru_unit i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (req_valid),
    .in_ready_o         (req_ready),
    .opcode_i           (req_op),
    .page_addr_i        (req_addr),
    .out_valid_o        (res_valid),
    .out_ready_i        (res_ready),
    .slot_o             (res_slot),
    .hit_o              (res_hit),
    .fill_needed_o      (res_fill),
    .writeback_needed_o (res_wb),
    .writeback_addr_o   (res_wb_addr)
  );

  slot_lru_checker i_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (req_valid),
    .in_ready_i         (req_ready),
    .opcode_i           (req_op),
    .page_addr_i        (req_addr),
    .out_valid_i        (res_valid),
    .out_ready_i        (res_ready),
    .slot_i             (res_slot),
    .hit_i              (res_hit),
    .fill_needed_i      (res_fill),
    .writeback_needed_i (res_wb),
    .writeback_addr_i   (res_wb_addr),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top failed");
    $finish;
  end

  initial begin
    res_ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // valid stays up across back-to-back beats, drops only for an idle gap
  task automatic request(input pbsm_pkg::op_e op,
                         input logic [pbsm_pkg::PAGE_ADDR_W-1:0] addr);
    bit known;
    known = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_op    <= op;
    req_addr  <= addr;
    do @(posedge clk); while (!req_ready);
    if (op == pbsm_pkg::OP_GET) begin
      n_get++;
      foreach (pages_seen[i]) if (pages_seen[i] == addr) known = 1'b1;
      if (!known) pages_seen.push_back(addr);
    end else begin
      n_release++;
    end
  endtask

  // mostly a small page pool so hits, evictions and releases all happen
  task automatic random_requests(input int unsigned count);
    pbsm_pkg::op_e op;
    logic [pbsm_pkg::PAGE_ADDR_W-1:0] addr;
    for (int unsigned n = 0; n < count; n++) begin
      op = ($urandom_range(3) == 0) ? pbsm_pkg::OP_RELEASE : pbsm_pkg::OP_GET;
      if ($urandom_range(4) == 0) addr = $urandom;
      else addr = page_pool[$urandom_range(POOL_SIZE - 1)];
      request(op, addr);
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    req_valid <= 1'b0;
    req_op    <= pbsm_pkg::OP_GET;
    req_addr  <= '0;
    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) page_pool[i] = $urandom;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    request(pbsm_pkg::OP_RELEASE, 32'h0000_0000);
    request(pbsm_pkg::OP_GET,     32'h0000_0000);
    request(pbsm_pkg::OP_GET,     32'hFFFF_FFFF);
    request(pbsm_pkg::OP_GET,     32'h0000_0000);
    request(pbsm_pkg::OP_RELEASE, 32'hFFFF_FFFF);
    request(pbsm_pkg::OP_RELEASE, 32'hFFFF_FFFF);
    request(pbsm_pkg::OP_GET,     32'hFFFF_FFFF);
    request(pbsm_pkg::OP_GET,     32'hAAAA_AAAA);
    request(pbsm_pkg::OP_GET,     32'h5555_5555);
    request(pbsm_pkg::OP_GET,     32'h8000_0000);
    request(pbsm_pkg::OP_GET,     32'h0000_0001);
    request(pbsm_pkg::OP_GET,     32'h7FFF_FFFF);
    request(pbsm_pkg::OP_GET,     32'h1234_5678);
    request(pbsm_pkg::OP_GET,     32'hFEDC_BA98);
    request(pbsm_pkg::OP_GET,     32'h0000_0000);
    request(pbsm_pkg::OP_RELEASE, 32'h5555_5555);
    request(pbsm_pkg::OP_GET,     32'hDEAD_BEEF);
    request(pbsm_pkg::OP_GET,     32'h5555_5555);

    random_requests(PER_PHASE);
    send_idle_pct = 55;
    recv_idle_pct = 36;
    random_requests(PER_PHASE);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_requests(PER_PHASE);

    // free every slot, then fill 0..7 in order so the ages are known
    for (int i = 0; i < pages_seen.size(); i++) request(pbsm_pkg::OP_RELEASE, pages_seen[i]);
    for (int i = 0; i < pbsm_pkg::SLOTS_DEF; i++) request(pbsm_pkg::OP_GET, 32'h5A00_0000 + i);
    // slot 1 made young, then a new page evicts the oldest slot
    request(pbsm_pkg::OP_GET, 32'h5A00_0001);
    request(pbsm_pkg::OP_GET, 32'hC0DE_0000);
    request(pbsm_pkg::OP_GET, 32'h5A00_0001);
    req_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (pbsm_pkg::SLOTS_DEF + 8) @(posedge clk);

    $display("ran %0d get and %0d release beats under three idle mixes,", n_get, n_release);
    $display("ending with a full release, an ordered refill and an oldest-slot eviction");
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/pbsm_pkg.sv
sv/page_buffer_slot_manager_lru_unit.sv
tb/slot_lru_checker.sv
tb/tb_top.sv
